>>> src/reference_table_stream_parser_defines.svh
`ifndef REFERENCE_TABLE_STREAM_PARSER_DEFINES_SVH
`define REFERENCE_TABLE_STREAM_PARSER_DEFINES_SVH

// condition holds in the same cycle
`define RTSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the next cycle
`define RTSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/rtsp_pkg.sv
`timescale 1ns / 1ps
package rtsp_pkg;

  localparam int unsigned MAX_ARCHIVES = 4096;
  localparam int unsigned AW = $clog2(MAX_ARCHIVES);
  localparam int unsigned PW = AW + 1;
  localparam logic [31:0] ID_LIMIT = 32'd1000000;
  localparam logic [31:0] MAX_ARCH_VAL = 32'(MAX_ARCHIVES);
  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QAW = $clog2(QDEPTH);
  localparam int unsigned QCW = $clog2(QDEPTH + 1);
  localparam int unsigned MAXREC = 3;

  typedef enum logic [3:0] {
    S_PROTO, S_TVER, S_FLAGS, S_ACOUNT, S_AIDS, S_NAMES, S_CRC, S_ALT,
    S_DIGEST, S_LENGTHS, S_VERS, S_FCOUNT, S_FIDS, S_FNAMES, S_IDLE
  } state_t;

  typedef enum logic [3:0] {
    K_PROTOCOL   = 4'd0,
    K_TABLEVER   = 4'd1,
    K_FLAGS      = 4'd2,
    K_ARCHIVEID  = 4'd3,
    K_NAMEHASH   = 4'd4,
    K_CRC        = 4'd5,
    K_ALTHASH    = 4'd6,
    K_ARCHVER    = 4'd7,
    K_FILECOUNT  = 4'd8,
    K_FILEID     = 4'd9,
    K_LARGEST    = 4'd10,
    K_DONE       = 4'd11,
    K_RANGEERROR = 4'd12,
    K_TRUNCATED  = 4'd13
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [19:0] index;
    logic [19:0] archive;
    logic [31:0] value;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic [PW-1:0] pos;
    logic [19:0]   count;
    logic [19:0]   aid;
  } ent_t;

  function automatic rec_t mk_rec(kind_t k, logic [19:0] idx, logic [19:0] arch,
                                  logic [31:0] val);
    rec_t r;
    r.kind = k;
    r.index = idx;
    r.archive = arch;
    r.value = val;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

>>> src/rtsp_front.sv
`timescale 1ns / 1ps
module rtsp_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               acc,
  input  logic [7:0]                         in_byte,
  input  logic                               in_first,
  input  logic                               in_last,
  input  logic [19:0]                        dfc,
  output logic [1:0]                         push_n,
  output rtsp_pkg::rec_t [rtsp_pkg::MAXREC-1:0] push_rec
);

  rtsp_pkg::state_t state, state_next, e_state;
  logic [31:0] accum, accum_next, e_accum;
  logic [2:0]  fcnt, fcnt_next, e_fcnt;
  logic [2:0]  fneed, fneed_next, e_fneed;
  logic [7:0]  proto, proto_next, e_proto;
  logic [3:0]  flags, flags_next, e_flags;
  logic [rtsp_pkg::PW-1:0] atotal, atotal_next, e_atotal;
  logic [rtsp_pkg::PW-1:0] apos, apos_next, e_apos;
  logic [19:0] fpos, fpos_next, e_fpos;
  logic [19:0] dsum, dsum_next, e_dsum;
  logic        bnone, bnone_next, e_bnone;
  logic [19:0] big, big_next, e_big;
  logic [31:0] skip, skip_next, e_skip;
  logic [31:0] tfiles, tfiles_next, e_tfiles;
  logic [rtsp_pkg::PW-1:0] li, li_next, e_li;
  logic [rtsp_pkg::PW-1:0] llen, llen_next, e_llen;

  logic [19:0] aid_mem [rtsp_pkg::MAX_ARCHIVES];
  rtsp_pkg::ent_t lst_mem [rtsp_pkg::MAX_ARCHIVES];
  logic [19:0] aid_rd;
  rtsp_pkg::ent_t lst_rd;
  logic aid_we, lst_we;
  logic [rtsp_pkg::AW-1:0] aid_wa, lst_wa, aid_ra, lst_ra;
  logic [19:0] aid_wd;
  rtsp_pkg::ent_t lst_wd;

  logic smart, feeding, fdone;
  logic [2:0] need, cnt1;
  logic [31:0] acc_sh, fv;
  logic [32:0] sum;
  logic [rtsp_pkg::PW-1:0] apos1;
  logic [20:0] fpos1;
  logic [31:0] skip1;
  logic [3:0] c_v;
  rtsp_pkg::rec_t [3:0] c_r;
  logic [1:0] n;

  function automatic logic [31:0] largest(logic [19:0] d, logic none, logic [19:0] b);
    logic [19:0] dm1;
    dm1 = d - 20'd1;
    if (d != 20'd0) return {12'd0, dm1};
    return none ? 32'hFFFF_FFFF : {12'd0, b};
  endfunction

  always_comb begin
    e_state  = in_first ? rtsp_pkg::S_PROTO : state;
    e_accum  = in_first ? 32'd0 : accum;
    e_fcnt   = in_first ? 3'd0 : fcnt;
    e_fneed  = in_first ? 3'd0 : fneed;
    e_proto  = in_first ? 8'd0 : proto;
    e_flags  = in_first ? 4'd0 : flags;
    e_atotal = in_first ? '0 : atotal;
    e_apos   = in_first ? '0 : apos;
    e_fpos   = in_first ? 20'd0 : fpos;
    e_dsum   = in_first ? 20'd0 : dsum;
    e_bnone  = in_first ? 1'b1 : bnone;
    e_big    = in_first ? 20'd0 : big;
    e_skip   = in_first ? 32'd0 : skip;
    e_tfiles = in_first ? 32'd0 : tfiles;
    e_li     = in_first ? '0 : li;
    e_llen   = in_first ? '0 : llen;

    smart = e_proto >= 8'd7;
    feeding = 1'b0;
    case (e_state)
      rtsp_pkg::S_TVER, rtsp_pkg::S_NAMES, rtsp_pkg::S_CRC, rtsp_pkg::S_ALT,
      rtsp_pkg::S_VERS: begin
        feeding = 1'b1;
        smart = 1'b0;
      end
      rtsp_pkg::S_ACOUNT, rtsp_pkg::S_AIDS, rtsp_pkg::S_FCOUNT, rtsp_pkg::S_FIDS: begin
        feeding = 1'b1;
      end
      default: begin
        feeding = 1'b0;
      end
    endcase

    if (e_fcnt != 3'd0) need = e_fneed;
    else if (smart) need = in_byte[7] ? 3'd4 : 3'd2;
    else if (e_state == rtsp_pkg::S_TVER || e_state == rtsp_pkg::S_NAMES ||
             e_state == rtsp_pkg::S_CRC || e_state == rtsp_pkg::S_ALT ||
             e_state == rtsp_pkg::S_VERS) need = 3'd4;
    else need = 3'd2;
    acc_sh = {e_accum[23:0], in_byte};
    cnt1 = e_fcnt + 3'd1;
    fdone = feeding && (cnt1 >= need);
    fv = acc_sh;
    if (smart) begin
      if (need == 3'd4) fv = acc_sh & 32'h7FFF_FFFF;
      else if (acc_sh == 32'h0000_7FFF) fv = 32'd0;
    end

    state_next = e_state;
    accum_next = e_accum;
    fcnt_next = e_fcnt;
    fneed_next = e_fneed;
    if (feeding) begin
      fneed_next = need;
      accum_next = fdone ? 32'd0 : acc_sh;
      fcnt_next = fdone ? 3'd0 : cnt1;
    end
    proto_next = e_proto;
    flags_next = e_flags;
    atotal_next = e_atotal;
    apos_next = e_apos;
    fpos_next = e_fpos;
    dsum_next = e_dsum;
    bnone_next = e_bnone;
    big_next = e_big;
    skip_next = e_skip;
    tfiles_next = e_tfiles;
    li_next = e_li;
    llen_next = e_llen;

    aid_we = 1'b0;
    aid_wa = e_apos[rtsp_pkg::AW-1:0];
    aid_wd = 20'd0;
    lst_we = 1'b0;
    lst_wa = e_llen[rtsp_pkg::AW-1:0];
    lst_wd = '0;

    c_v = '0;
    c_r = '0;
    sum = '0;
    apos1 = e_apos + 1'b1;
    fpos1 = {1'b0, e_fpos} + 21'd1;
    skip1 = (e_skip != 32'd0) ? e_skip - 32'd1 : 32'd0;

    case (e_state)
      rtsp_pkg::S_PROTO: begin
        proto_next = in_byte;
        c_v[0] = 1'b1;
        c_r[0] = rtsp_pkg::mk_rec(rtsp_pkg::K_PROTOCOL, 20'd0, 20'd0, {24'd0, in_byte});
        state_next = (in_byte >= 8'd6) ? rtsp_pkg::S_TVER : rtsp_pkg::S_FLAGS;
      end
      rtsp_pkg::S_TVER: begin
        if (fdone) begin
          c_v[0] = 1'b1;
          c_r[0] = rtsp_pkg::mk_rec(rtsp_pkg::K_TABLEVER, 20'd0, 20'd0, fv);
          state_next = rtsp_pkg::S_FLAGS;
        end
      end
      rtsp_pkg::S_FLAGS: begin
        flags_next = in_byte[3:0];
        c_v[0] = 1'b1;
        c_r[0] = rtsp_pkg::mk_rec(rtsp_pkg::K_FLAGS, 20'd0, 20'd0, {24'd0, in_byte});
        state_next = rtsp_pkg::S_ACOUNT;
      end
      rtsp_pkg::S_ACOUNT: begin
        if (fdone) begin
          c_v[0] = 1'b1;
          if (fv > rtsp_pkg::ID_LIMIT || fv > rtsp_pkg::MAX_ARCH_VAL) begin
            c_r[0] = rtsp_pkg::mk_rec(rtsp_pkg::K_RANGEERROR, 20'd0, 20'd0, fv);
            state_next = rtsp_pkg::S_IDLE;
          end else begin
            atotal_next = fv[rtsp_pkg::PW-1:0];
            tfiles_next = 32'd0;
            dsum_next = 20'd0;
            apos_next = '0;
            if (fv == 32'd0) begin
              c_r[0] = rtsp_pkg::mk_rec(rtsp_pkg::K_DONE, 20'd0, 20'd0, 32'd0);
              state_next = rtsp_pkg::S_IDLE;
            end else begin
              c_v[0] = 1'b0;
              state_next = rtsp_pkg::S_AIDS;
            end
          end
        end
      end
      rtsp_pkg::S_AIDS: begin
        if (fdone) begin
          sum = {13'd0, e_dsum} + {1'b0, fv};
          c_v[0] = 1'b1;
          if (sum > {1'b0, rtsp_pkg::ID_LIMIT}) begin
            c_r[0] = rtsp_pkg::mk_rec(rtsp_pkg::K_RANGEERROR, 20'd0, 20'd0, sum[31:0]);
            state_next = rtsp_pkg::S_IDLE;
          end else begin
            dsum_next = sum[19:0];
            aid_we = 1'b1;
            aid_wd = sum[19:0];
            c_r[0] = rtsp_pkg::mk_rec(rtsp_pkg::K_ARCHIVEID, 20'(e_apos), sum[19:0],
                                      sum[31:0]);
            if (apos1 >= e_atotal) begin
              apos_next = '0;
              state_next = e_flags[0] ? rtsp_pkg::S_NAMES : rtsp_pkg::S_CRC;
            end else begin
              apos_next = apos1;
            end
          end
        end
      end
      rtsp_pkg::S_NAMES, rtsp_pkg::S_CRC, rtsp_pkg::S_ALT, rtsp_pkg::S_VERS: begin
        if (fdone) begin
          c_v[0] = 1'b1;
          case (e_state)
            rtsp_pkg::S_NAMES: c_r[0] = rtsp_pkg::mk_rec(rtsp_pkg::K_NAMEHASH,
                                 20'(e_apos), aid_rd, fv);
            rtsp_pkg::S_CRC: c_r[0] = rtsp_pkg::mk_rec(rtsp_pkg::K_CRC,
                               20'(e_apos), aid_rd, fv);
            rtsp_pkg::S_ALT: c_r[0] = rtsp_pkg::mk_rec(rtsp_pkg::K_ALTHASH,
                               20'(e_apos), aid_rd, fv);
            default: c_r[0] = rtsp_pkg::mk_rec(rtsp_pkg::K_ARCHVER,
                               20'(e_apos), aid_rd, fv);
          endcase
          if (apos1 >= e_atotal) begin
            apos_next = '0;
            case (e_state)
              rtsp_pkg::S_NAMES: state_next = rtsp_pkg::S_CRC;
              rtsp_pkg::S_VERS: state_next = rtsp_pkg::S_FCOUNT;
              default: begin
                if (e_state == rtsp_pkg::S_CRC && e_flags[3]) begin
                  state_next = rtsp_pkg::S_ALT;
                end else if (e_flags[1]) begin
                  state_next = rtsp_pkg::S_DIGEST;
                  skip_next = {13'd0, e_atotal, 6'd0};
                end else if (e_flags[2]) begin
                  state_next = rtsp_pkg::S_LENGTHS;
                  skip_next = {16'd0, e_atotal, 3'd0};
                end else begin
                  state_next = rtsp_pkg::S_VERS;
                end
              end
            endcase
          end else begin
            apos_next = apos1;
          end
        end
      end
      rtsp_pkg::S_DIGEST, rtsp_pkg::S_LENGTHS: begin
        skip_next = skip1;
        if (skip1 == 32'd0) begin
          apos_next = '0;
          if (e_state == rtsp_pkg::S_DIGEST && e_flags[2]) begin
            state_next = rtsp_pkg::S_LENGTHS;
            skip_next = {16'd0, e_atotal, 3'd0};
          end else begin
            state_next = rtsp_pkg::S_VERS;
          end
        end
      end
      rtsp_pkg::S_FCOUNT: begin
        if (fdone) begin
          c_v[0] = 1'b1;
          if (fv > rtsp_pkg::ID_LIMIT) begin
            c_r[0] = rtsp_pkg::mk_rec(rtsp_pkg::K_RANGEERROR, 20'd0, 20'd0, fv);
            state_next = rtsp_pkg::S_IDLE;
          end else begin
            tfiles_next = e_tfiles + fv;
            c_r[0] = rtsp_pkg::mk_rec(rtsp_pkg::K_FILECOUNT, 20'(e_apos), aid_rd, fv);
            if (fv == 32'd0) begin
              c_v[1] = 1'b1;
              c_r[1] = rtsp_pkg::mk_rec(rtsp_pkg::K_LARGEST, 20'(e_apos), aid_rd,
                                        largest(dfc, 1'b1, 20'd0));
            end else begin
              lst_we = 1'b1;
              lst_wd.pos = e_apos;
              lst_wd.count = fv[19:0];
              lst_wd.aid = aid_rd;
              llen_next = e_llen + 1'b1;
            end
            if (apos1 >= e_atotal) begin
              apos_next = '0;
              if (llen_next != '0) begin
                state_next = rtsp_pkg::S_FIDS;
                li_next = '0;
                fpos_next = 20'd0;
                dsum_next = 20'd0;
                bnone_next = 1'b1;
              end else if (e_flags[0] && tfiles_next != 32'd0) begin
                state_next = rtsp_pkg::S_FNAMES;
                skip_next = tfiles_next;
              end else begin
                c_v[2] = 1'b1;
                c_r[2] = rtsp_pkg::mk_rec(rtsp_pkg::K_DONE, 20'd0, 20'd0, 32'd0);
                state_next = rtsp_pkg::S_IDLE;
              end
            end else begin
              apos_next = apos1;
            end
          end
        end
      end
      rtsp_pkg::S_FIDS: begin
        if (fdone) begin
          sum = {13'd0, e_dsum} + {1'b0, fv};
          c_v[0] = 1'b1;
          if (sum > {1'b0, rtsp_pkg::ID_LIMIT}) begin
            c_r[0] = rtsp_pkg::mk_rec(rtsp_pkg::K_RANGEERROR, 20'd0, 20'd0, sum[31:0]);
            state_next = rtsp_pkg::S_IDLE;
          end else begin
            dsum_next = sum[19:0];
            if (e_bnone || sum[19:0] > e_big) begin
              bnone_next = 1'b0;
              big_next = sum[19:0];
            end
            c_r[0] = rtsp_pkg::mk_rec(rtsp_pkg::K_FILEID, e_fpos, lst_rd.aid, sum[31:0]);
            if (fpos1 >= {1'b0, lst_rd.count}) begin
              c_v[1] = 1'b1;
              c_r[1] = rtsp_pkg::mk_rec(rtsp_pkg::K_LARGEST, 20'(lst_rd.pos), lst_rd.aid,
                                        largest(dfc, bnone_next, big_next));
              if (e_li + 1'b1 < e_llen) begin
                li_next = e_li + 1'b1;
                fpos_next = 20'd0;
                dsum_next = 20'd0;
                bnone_next = 1'b1;
              end else begin
                apos_next = '0;
                if (e_flags[0] && e_tfiles != 32'd0) begin
                  state_next = rtsp_pkg::S_FNAMES;
                  skip_next = e_tfiles;
                end else begin
                  c_v[2] = 1'b1;
                  c_r[2] = rtsp_pkg::mk_rec(rtsp_pkg::K_DONE, 20'd0, 20'd0, 32'd0);
                  state_next = rtsp_pkg::S_IDLE;
                end
              end
            end else begin
              fpos_next = fpos1[19:0];
            end
          end
        end
      end
      rtsp_pkg::S_FNAMES: begin
        if (cnt1 >= 3'd4) begin
          fcnt_next = 3'd0;
          skip_next = skip1;
          if (skip1 == 32'd0) begin
            c_v[0] = 1'b1;
            c_r[0] = rtsp_pkg::mk_rec(rtsp_pkg::K_DONE, 20'd0, 20'd0, 32'd0);
            state_next = rtsp_pkg::S_IDLE;
          end
        end else begin
          fcnt_next = cnt1;
        end
      end
      default: begin
        state_next = e_state;
      end
    endcase

    if (in_last && state_next != rtsp_pkg::S_IDLE) begin
      c_v[3] = 1'b1;
      c_r[3] = rtsp_pkg::mk_rec(rtsp_pkg::K_TRUNCATED, 20'd0, 20'd0, 32'd0);
      state_next = rtsp_pkg::S_IDLE;
    end

    n = 2'd0;
    push_rec = '0;
    for (int i = 0; i < 4; i++) begin
      if (c_v[i] && n != 2'd3) begin
        push_rec[n] = c_r[i];
        n = n + 2'd1;
      end
    end
    if (in_last && n != 2'd0) push_rec[n - 2'd1].last = 1'b1;
    push_n = acc ? n : 2'd0;

    aid_ra = acc ? apos_next[rtsp_pkg::AW-1:0] : apos[rtsp_pkg::AW-1:0];
    lst_ra = acc ? li_next[rtsp_pkg::AW-1:0] : li[rtsp_pkg::AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (acc && aid_we) aid_mem[aid_wa] <= aid_wd;
    if (acc && aid_we && aid_wa == aid_ra) aid_rd <= aid_wd;
    else aid_rd <= aid_mem[aid_ra];
  end

  always_ff @(posedge clk) begin
    if (acc && lst_we) lst_mem[lst_wa] <= lst_wd;
    if (acc && lst_we && lst_wa == lst_ra) lst_rd <= lst_wd;
    else lst_rd <= lst_mem[lst_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtsp_pkg::S_PROTO;
      accum <= 32'd0;
      fcnt <= 3'd0;
      fneed <= 3'd0;
      proto <= 8'd0;
      flags <= 4'd0;
      atotal <= '0;
      apos <= '0;
      fpos <= 20'd0;
      dsum <= 20'd0;
      bnone <= 1'b1;
      big <= 20'd0;
      skip <= 32'd0;
      tfiles <= 32'd0;
      li <= '0;
      llen <= '0;
    end else if (acc) begin
      state <= state_next;
      accum <= accum_next;
      fcnt <= fcnt_next;
      fneed <= fneed_next;
      proto <= proto_next;
      flags <= flags_next;
      atotal <= atotal_next;
      apos <= apos_next;
      fpos <= fpos_next;
      dsum <= dsum_next;
      bnone <= bnone_next;
      big <= big_next;
      skip <= skip_next;
      tfiles <= tfiles_next;
      li <= li_next;
      llen <= llen_next;
    end
  end

endmodule

>>> src/rtsp_queue.sv
`timescale 1ns / 1ps
module rtsp_queue (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [1:0]                            push_n,
  input  rtsp_pkg::rec_t [rtsp_pkg::MAXREC-1:0] push_rec,
  input  logic                                  pop,
  output rtsp_pkg::rec_t                        head,
  output logic                                  head_valid,
  output logic                                  room,
  output logic [rtsp_pkg::QCW-1:0]              count
);

  rtsp_pkg::rec_t mem [rtsp_pkg::QDEPTH];
  logic [rtsp_pkg::QAW-1:0] wp, rp;
  logic [rtsp_pkg::QCW-1:0] count_next;

  assign head = mem[rp];
  assign head_valid = count != '0;
  assign room = count <= rtsp_pkg::QCW'(rtsp_pkg::QDEPTH - rtsp_pkg::MAXREC);
  assign count_next = count + rtsp_pkg::QCW'(push_n) - rtsp_pkg::QCW'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < rtsp_pkg::MAXREC; i++) begin
      if (2'(i) < push_n) mem[wp + rtsp_pkg::QAW'(i)] <= push_rec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      wp <= wp + rtsp_pkg::QAW'(push_n);
      rp <= rp + rtsp_pkg::QAW'(pop);
      count <= count_next;
    end
  end

endmodule

>>> src/rtsp_back.sv
`timescale 1ns / 1ps
module rtsp_back (
  input  logic           clk,
  input  logic           rst,
  input  rtsp_pkg::rec_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           rec_valid,
  input  logic           rec_ready,
  output rtsp_pkg::rec_t rec
);

  assign pop = head_valid && (!rec_valid || rec_ready);

  always_ff @(posedge clk) begin
    if (pop) rec <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (pop) begin
      rec_valid <= 1'b1;
    end else if (rec_ready) begin
      rec_valid <= 1'b0;
    end
  end

endmodule

>>> src/reference_table_stream_parser.sv
// a byte's records are written into the record queue as the byte is accepted, then into the output register
// throughput: one byte per cycle while the record queue holds five or fewer entries
// records leave at one per cycle while rec_ready is held high; a byte yields up to three, queued eight deep
// reset (synchronous, active high) returns the parser to the protocol byte,
// empties the queue and clears default_file_count; table memories are not cleared
`timescale 1ns / 1ps
`include "reference_table_stream_parser_defines.svh"
module reference_table_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_first,
  input  logic        in_last,
  output logic        rec_valid,
  input  logic        rec_ready,
  output logic [3:0]  rec_kind,
  output logic [19:0] rec_index,
  output logic [19:0] rec_archive,
  output logic [31:0] rec_value,
  output logic        rec_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [19:0] dfc;
  logic acc, room, head_valid, pop;
  logic [1:0] push_n;
  rtsp_pkg::rec_t [rtsp_pkg::MAXREC-1:0] push_rec;
  rtsp_pkg::rec_t head, rec;
  logic [rtsp_pkg::QCW-1:0] q_count;

  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {12'd0, dfc} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dfc <= 20'd0;
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      dfc <= pwdata[19:0];
    end
  end

  assign in_ready = room;
  assign acc = in_valid && room;

  rtsp_front u_front (
    .clk(clk), .rst(rst), .acc(acc), .in_byte(in_byte), .in_first(in_first),
    .in_last(in_last), .dfc(dfc), .push_n(push_n), .push_rec(push_rec)
  );

  rtsp_queue u_queue (
    .clk(clk), .rst(rst), .push_n(push_n), .push_rec(push_rec), .pop(pop),
    .head(head), .head_valid(head_valid), .room(room), .count(q_count)
  );

  rtsp_back u_back (
    .clk(clk), .rst(rst), .head(head), .head_valid(head_valid), .pop(pop),
    .rec_valid(rec_valid), .rec_ready(rec_ready), .rec(rec)
  );

  assign rec_kind = rec.kind;
  assign rec_index = rec.index;
  assign rec_archive = rec.archive;
  assign rec_value = rec.value;
  assign rec_last = rec.last;

  `RTSP_ASSERT_NOW(a_q_bound, 1'b1, q_count <= rtsp_pkg::QCW'(rtsp_pkg::QDEPTH), "queue overflow")
  `RTSP_ASSERT_NOW(a_room, in_ready, q_count <= rtsp_pkg::QCW'(rtsp_pkg::QDEPTH - rtsp_pkg::MAXREC), "ready without room")
  `RTSP_ASSERT_NEXT(a_fill, head_valid && !rec_valid, rec_valid, "queued record not moved out")

endmodule

>>> dv/table_record_checker.sv
`timescale 1ns / 1ps
module table_record_checker
  import rtsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_first,
  input  logic        in_last,
  input  logic        rec_valid,
  input  logic        rec_ready,
  input  logic [3:0]  rec_kind,
  input  logic [19:0] rec_index,
  input  logic [19:0] rec_archive,
  input  logic [31:0] rec_value,
  input  logic        rec_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          pending,
  output int          records_seen
);

  localparam logic [2:0] ADDR_DFC = 3'd0;
  localparam int unsigned NO_FILE = 32'h1FFFFF;

  rec_t        want_recs[$];
  rec_t        step_recs[$];
  logic [19:0] dfc;
  state_t      pstate;
  logic [31:0] acc;
  int unsigned nbytes, need;
  logic [7:0]  proto;
  logic [3:0]  flg;
  int unsigned atotal, apos, fpos, dsum, big, skip, tfiles;
  int unsigned aid_mem[MAX_ARCHIVES];
  int unsigned fcnt_mem[MAX_ARCHIVES];

  assign pending = want_recs.size();

  function automatic void put_rec(kind_t k, int unsigned idx, int unsigned arch,
                                  logic [31:0] val);
    rec_t r;
    if (step_recs.size() >= MAXREC) return;
    r.kind = k;
    r.index = idx[19:0];
    r.archive = arch[19:0];
    r.value = val;
    r.last = 1'b0;
    step_recs.push_back(r);
  endfunction

  function automatic void restart_parse();
    pstate = S_PROTO;
    acc = 0; nbytes = 0; need = 0; proto = 0; flg = 0;
    atotal = 0; apos = 0; fpos = 0; dsum = 0;
    big = NO_FILE; skip = 0; tfiles = 0;
  endfunction

  function automatic bit take_field(logic [7:0] b, bit smart, int unsigned fixed,
                                    output logic [31:0] val);
    if (nbytes == 0) need = smart ? (b[7] ? 4 : 2) : fixed;
    acc = {acc[23:0], b};
    nbytes++;
    if (nbytes < need) return 0;
    val = acc;
    if (smart) begin
      if (need == 4) val[31] = 1'b0;
      else if (val == 32'h7FFF) val = 0;
    end
    acc = 0; nbytes = 0;
    return 1;
  endfunction

  function automatic logic [31:0] largest_of(int unsigned b);
    if (dfc != 0) return 32'(dfc) - 1;
    return (b == NO_FILE) ? 32'hFFFFFFFF : b;
  endfunction

  function automatic bit next_with_files(int unsigned p);
    while (p < atotal && p < MAX_ARCHIVES && fcnt_mem[p] == 0) p++;
    if (p >= atotal || p >= MAX_ARCHIVES) return 0;
    apos = p; fpos = 0; dsum = 0; big = NO_FILE;
    return 1;
  endfunction

  function automatic void finish_table();
    put_rec(K_DONE, 0, 0, 0);
    pstate = S_IDLE;
  endfunction

  function automatic void enter_section(state_t s);
    apos = 0; acc = 0; nbytes = 0;
    forever begin
      case (s)
        S_NAMES: begin
          if (flg[0]) begin pstate = s; return; end
          s = S_CRC;
        end
        S_ALT: begin
          if (flg[3]) begin pstate = s; return; end
          s = S_DIGEST;
        end
        S_DIGEST: begin
          if (flg[1]) begin skip = atotal * 64; pstate = s; return; end
          s = S_LENGTHS;
        end
        S_LENGTHS: begin
          if (flg[2]) begin skip = atotal * 8; pstate = s; return; end
          s = S_VERS;
        end
        S_FIDS: begin
          if (next_with_files(0)) begin pstate = s; return; end
          s = S_FNAMES;
        end
        S_FNAMES: begin
          if (flg[0] && tfiles > 0) begin skip = tfiles; pstate = s; return; end
          finish_table();
          return;
        end
        default: begin pstate = s; return; end
      endcase
    end
  endfunction

  function automatic void range_fault(logic [31:0] v);
    put_rec(K_RANGEERROR, 0, 0, v);
    pstate = S_IDLE; acc = 0; nbytes = 0;
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic first, logic last);
    bit smart;
    logic [31:0] v;
    longint unsigned sum;
    kind_t k;
    int unsigned cur;
    step_recs.delete();
    if (first) restart_parse();
    smart = proto >= 7;
    cur = aid_mem[apos % MAX_ARCHIVES];
    case (pstate)
      S_PROTO: begin
        proto = b;
        put_rec(K_PROTOCOL, 0, 0, b);
        pstate = (b >= 6) ? S_TVER : S_FLAGS;
      end
      S_TVER: if (take_field(b, 0, 4, v)) begin
        put_rec(K_TABLEVER, 0, 0, v);
        pstate = S_FLAGS;
      end
      S_FLAGS: begin
        flg = b[3:0];
        put_rec(K_FLAGS, 0, 0, b);
        pstate = S_ACOUNT;
      end
      S_ACOUNT: if (take_field(b, smart, 2, v)) begin
        if (v > ID_LIMIT || v > MAX_ARCH_VAL) range_fault(v);
        else begin
          atotal = v; tfiles = 0; dsum = 0; apos = 0;
          if (v == 0) finish_table();
          else pstate = S_AIDS;
        end
      end
      S_AIDS: if (take_field(b, smart, 2, v)) begin
        sum = longint'(dsum) + v;
        if (sum > ID_LIMIT) range_fault(sum[31:0]);
        else begin
          dsum = sum;
          if (apos < MAX_ARCHIVES) aid_mem[apos] = dsum;
          put_rec(K_ARCHIVEID, apos, dsum, dsum);
          apos++;
          if (apos >= atotal) enter_section(S_NAMES);
        end
      end
      S_NAMES, S_CRC, S_ALT, S_VERS: if (take_field(b, 0, 4, v)) begin
        k = (pstate == S_NAMES) ? K_NAMEHASH : (pstate == S_CRC) ? K_CRC :
            (pstate == S_ALT) ? K_ALTHASH : K_ARCHVER;
        put_rec(k, apos, cur, v);
        apos++;
        if (apos >= atotal)
          enter_section((pstate == S_NAMES) ? S_CRC : (pstate == S_CRC) ? S_ALT :
                        (pstate == S_ALT) ? S_DIGEST : S_FCOUNT);
      end
      S_DIGEST, S_LENGTHS: begin
        if (skip > 0) skip--;
        if (skip == 0) enter_section((pstate == S_DIGEST) ? S_LENGTHS : S_VERS);
      end
      S_FCOUNT: if (take_field(b, smart, 2, v)) begin
        if (v > ID_LIMIT) range_fault(v);
        else begin
          if (apos < MAX_ARCHIVES) fcnt_mem[apos] = v;
          sum = longint'(tfiles) + v;
          tfiles = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sum;
          put_rec(K_FILECOUNT, apos, cur, v);
          if (v == 0) put_rec(K_LARGEST, apos, cur, largest_of(NO_FILE));
          apos++;
          if (apos >= atotal) enter_section(S_FIDS);
        end
      end
      S_FIDS: if (take_field(b, smart, 2, v)) begin
        sum = longint'(dsum) + v;
        if (sum > ID_LIMIT) range_fault(sum[31:0]);
        else begin
          dsum = sum;
          if (big == NO_FILE || dsum > big) big = dsum;
          put_rec(K_FILEID, fpos, cur, dsum);
          fpos++;
          if (fpos >= fcnt_mem[apos % MAX_ARCHIVES]) begin
            put_rec(K_LARGEST, apos, cur, largest_of(big));
            if (!next_with_files(apos + 1)) enter_section(S_FNAMES);
          end
        end
      end
      S_FNAMES: begin
        nbytes++;
        if (nbytes >= 4) begin
          nbytes = 0;
          if (skip > 0) skip--;
          if (skip == 0) finish_table();
        end
      end
      default: ;
    endcase
    if (last && pstate != S_IDLE) begin
      put_rec(K_TRUNCATED, 0, 0, 0);
      pstate = S_IDLE;
    end
    if (last && step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
    foreach (step_recs[i]) want_recs.push_back(step_recs[i]);
  endfunction

  always @(posedge clk) begin
    rec_t w;
    if (rst) begin
      want_recs.delete();
      restart_parse();
      dfc = 0;
      errors = 0;
      records_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_DFC) dfc = pwdata[19:0];
      if (in_valid && in_ready) parse_byte(in_byte, in_first, in_last);
      if (rec_valid && rec_ready) begin
        records_seen++;
        if (want_recs.size() == 0) begin
          errors++;
          $display("%0t: unexpected record kind %0d value %h", $time, rec_kind, rec_value);
        end else begin
          w = want_recs.pop_front();
          if (rec_kind != w.kind || rec_index != w.index || rec_archive != w.archive ||
              rec_value != w.value || rec_last != w.last) begin
            errors++;
            $display("%0t: record mismatch expected kind %0d index %0d archive %0d value %h last %0d",
                     $time, w.kind, w.index, w.archive, w.value, w.last);
            $display("%0t:                 actual   kind %0d index %0d archive %0d value %h last %0d",
                     $time, rec_kind, rec_index, rec_archive, rec_value, rec_last);
          end
        end
      end
    end
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import rtsp_pkg::*;

  localparam logic [2:0] ADDR_DFC = 3'd0;
  localparam int F_NONE = 0, F_TRUNC = 1, F_TRAIL = 2, F_ID_OVER = 3, F_CNT_OVER = 4,
                 F_ARCH_OVER = 5, F_NOISE = 6;

  logic        clk = 0, rst = 1;
  logic        in_valid = 0, in_first = 0, in_last = 0;
  logic [7:0]  in_byte = 0;
  logic        in_ready;
  logic        rec_valid, rec_ready = 0, rec_last;
  logic [3:0]  rec_kind;
  logic [19:0] rec_index, rec_archive;
  logic [31:0] rec_value, prdata;
  logic        psel = 0, penable = 0, pwrite = 0, pready;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  int          errors, pending, records_seen;
  int          bytes_sent = 0, blobs_sent = 0;
  bit          quiet = 0, long_hold = 0;
  logic [7:0]  blob[$];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  reference_table_stream_parser i_dut (.*);

  table_record_checker i_chk (.*);

  // receiver: random backpressure per transaction, plus one long hold
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (long_hold) begin
        gap = 120;
        long_hold = 0;
      end
      repeat (gap) @(negedge clk) rec_ready <= 0;
      @(negedge clk) rec_ready <= 1;
      do @(posedge clk); while (!(rec_valid && rec_ready));
    end
  end

  task automatic send_byte(logic [7:0] b, logic f, logic l);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    repeat (gap) @(negedge clk) in_valid <= 0;
    @(negedge clk);
    in_valid <= 1; in_byte <= b; in_first <= f; in_last <= l;
    do @(posedge clk); while (!(in_valid && in_ready));
    bytes_sent++;
  endtask

  task automatic send_blob();
    foreach (blob[i]) send_byte(blob[i], i == 0, i == blob.size() - 1);
    @(negedge clk) in_valid <= 0;
    blobs_sent++;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_dfc(logic [19:0] v);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_DFC; pwdata <= 32'(v);
    @(negedge clk) penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  function automatic void put_u32(logic [31:0] v);
    blob.push_back(v[31:24]); blob.push_back(v[23:16]);
    blob.push_back(v[15:8]);  blob.push_back(v[7:0]);
  endfunction

  function automatic void put_num(int unsigned v, bit smart);
    logic [31:0] w;
    if (!smart) begin
      blob.push_back(v[15:8]); blob.push_back(v[7:0]);
    end else if (v >= 32'h7FFF || (v != 0 && $urandom_range(0, 5) == 0)) begin
      w = v | 32'h80000000;
      put_u32(w);
    end else if (v == 0 && $urandom_range(0, 1) == 1) begin
      blob.push_back(8'h7F); blob.push_back(8'hFF);
    end else begin
      blob.push_back(v[15:8]); blob.push_back(v[7:0]);
    end
  endfunction

  function automatic void build_blob(logic [7:0] proto, logic [7:0] flags, int n,
                                     int maxf, int fault);
    bit smart;
    int unsigned sum, d, total, k;
    int unsigned cnt[$];
    smart = proto >= 7;
    blob.delete();
    blob.push_back(proto);
    if (proto >= 6) put_u32($urandom);
    blob.push_back(flags);
    if (fault == F_ARCH_OVER) begin
      put_num(4097 + $urandom_range(0, 10), smart);
      return;
    end
    put_num(n, smart);
    if (n == 0) return;
    sum = 0;
    for (int i = 0; i < n; i++) begin
      d = $urandom_range(0, smart ? 300000 : 3000);
      if (sum + d > ID_LIMIT) d = ID_LIMIT - sum;
      if (fault == F_ID_OVER && i == n - 1) begin
        put_num(ID_LIMIT + 1 - sum + $urandom_range(0, 3), 1);
        return;
      end
      put_num(d, smart);
      sum += d;
    end
    if (flags[0]) repeat (n) put_u32($urandom);
    repeat (n) put_u32($urandom);
    if (flags[3]) repeat (n) put_u32($urandom);
    if (flags[1]) repeat (64 * n) blob.push_back($urandom);
    if (flags[2]) repeat (8 * n) blob.push_back($urandom);
    repeat (n) put_u32($urandom);
    total = 0;
    for (int i = 0; i < n; i++) begin
      if (fault == F_CNT_OVER && i == n - 1) begin
        put_num(ID_LIMIT + 1 + $urandom_range(0, 5), 1);
        return;
      end
      cnt.push_back($urandom_range(0, maxf));
      put_num(cnt[i], smart);
      total += cnt[i];
    end
    foreach (cnt[i]) begin
      sum = 0;
      repeat (cnt[i]) begin
        d = $urandom_range(0, smart ? 50000 : 2000);
        if (sum + d > ID_LIMIT) d = ID_LIMIT - sum;
        put_num(d, smart);
        sum += d;
      end
    end
    if (flags[0]) repeat (4 * total) blob.push_back($urandom);
    if (fault == F_TRAIL) repeat ($urandom_range(1, 5)) blob.push_back($urandom);
    if (fault == F_TRUNC && blob.size() > 1) begin
      k = $urandom_range(1, blob.size() - 1);
      blob = blob[0:k-1];
    end
  endfunction

  task automatic run_blob(logic [7:0] proto, logic [7:0] flags, int n, int maxf, int fault);
    if (fault == F_NOISE) begin
      blob.delete();
      repeat ($urandom_range(1, 12)) blob.push_back($urandom);
    end else begin
      build_blob(proto, flags, n, maxf, fault);
      if (fault == F_ID_OVER || fault == F_CNT_OVER || fault == F_ARCH_OVER)
        repeat ($urandom_range(0, 3)) blob.push_back($urandom);
    end
    send_blob();
  endtask

  task automatic random_phase(int count);
    int r, pick, fault, n;
    logic [7:0] proto, flags;
    repeat (count) begin
      quiet = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 19);
      fault = (r < 12) ? F_NONE : (r < 14) ? F_TRUNC : (r == 14) ? F_TRAIL :
              (r == 15) ? F_ID_OVER : (r == 16) ? F_CNT_OVER :
              (r == 17) ? F_ARCH_OVER : F_NOISE;
      pick = $urandom_range(0, 3);
      proto = (pick == 0) ? $urandom_range(0, 5) : (pick == 1) ? 8'd6 :
              (pick == 2) ? 8'd7 : $urandom_range(8, 255);
      if (fault == F_ID_OVER || fault == F_CNT_OVER) proto = $urandom_range(7, 255);
      flags = $urandom;
      if ($urandom_range(0, 3) != 0) flags[1] = 0;
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      run_blob(proto, flags, n, $urandom_range(0, 4), fault);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 0;

    // directed: empty table, each protocol style, errors, truncation, trailing bytes
    quiet = 1;
    run_blob(8'd0, 8'h00, 0, 0, F_NONE);
    run_blob(8'd5, 8'h09, 1, 0, F_NONE);
    quiet = 0;
    run_blob(8'd6, 8'hF5, 2, 2, F_NONE);
    run_blob(8'd7, 8'h08, 2, 3, F_TRAIL);
    run_blob(8'd255, 8'h00, 1, 2, F_ID_OVER);
    run_blob(8'd7, 8'h00, 2, 2, F_CNT_OVER);
    run_blob(8'd5, 8'h00, 1, 1, F_ARCH_OVER);
    run_blob(8'd6, 8'h01, 2, 2, F_TRUNC);
    wait_idle();

    write_dfc(20'd1000000);
    long_hold = 1;
    quiet = 1;
    run_blob(8'd7, 8'h0C, 3, 4, F_NONE);
    random_phase(8);
    wait_idle();

    write_dfc(20'd1);
    random_phase(8);
    wait_idle();

    write_dfc($urandom_range(2, 999999));
    random_phase(8);
    wait_idle();

    write_dfc(20'd0);
    random_phase(14);
    wait_idle();
    repeat (20) @(posedge clk);

    $display("covered %0d bytes in %0d blobs, %0d records checked", bytes_sent, blobs_sent,
             records_seen);
    $display("default_file_count settings 0, 1, 1000000 and a random value were applied");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/rtsp_pkg.sv
src/rtsp_front.sv
src/rtsp_queue.sv
src/rtsp_back.sv
src/reference_table_stream_parser.sv
dv/table_record_checker.sv
dv/tb.sv
